// ===== rtl/idal_pkg.sv =====
// ----------------------------------------------------------------------------
// idal_pkg
// Shared types and constants of the identifier allocator with free list.
// ----------------------------------------------------------------------------
package idal_pkg;

   // number of identifiers handed out, identifiers run from 1 to MaxIds
   localparam int MaxIds     = 1024;
   // width of an identifier on the ports, holds 0 to MaxIds
   localparam int IdWidth    = 11;
   // width of a slot or a zero-based identifier index
   localparam int IdxWidth   = $clog2(MaxIds);
   // width of the queue fill count, holds 0 to MaxIds
   localparam int CountWidth = $clog2(MaxIds + 1);

   typedef enum logic {
      MODE_ALLOC   = 1'b0,
      MODE_RELEASE = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EXHAUSTED = 2'd1,
      STATUS_UNISSUED  = 2'd2,
      STATUS_DUPLICATE = 2'd3
   } status_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   // request transaction
   typedef struct packed {
      mode_type             mode;
      logic [IdWidth-1:0]   release_id;
   } req_type;

   // response transaction
   typedef struct packed {
      logic [IdWidth-1:0]   granted_id;
      status_type           status;
   } rsp_type;

   // free queue commands
   typedef struct packed {
      logic                 push;
      logic                 pop;
      logic [IdxWidth-1:0]  push_idx;
   } queue_ctrl_type;

   // free queue status
   typedef struct packed {
      logic                 empty;
      logic                 full;
   } queue_status_type;

   // mark bitmap write port
   typedef struct packed {
      logic                 en;
      logic [IdxWidth-1:0]  addr;
      logic                 value;
   } mark_wr_type;

endpackage

// ===== rtl/id_allocator_free_list_unit.sv =====
// ----------------------------------------------------------------------------
// id_allocator_free_list_unit
// Identifier allocator: reuses released identifiers in FIFO order, otherwise
// issues fresh ones from a counter, and checks releases against a bitmap.
// ----------------------------------------------------------------------------
//  channel   ports                      direction  handshake
//  request   start, busy, req_data      in         taken when start & !busy
//  response  rsp_valid, rsp_data        out        one-cycle strobe, no stall
//
//  The accept edge launches the reads of the free queue head and of the
//  mark bitmap, the next edge writes both memories back and registers the
//  response. busy is high for a single cycle, in the execute state, so no new
//  transaction is taken before the last one is through; the response strobe
//  is registered from the execute state. Synchronous reset clears the slots,
//  counters and the fresh counter; the bitmap needs no clearing, as an entry
//  is written when its identifier is first issued.
//  The receiver cannot stall the response.
// ----------------------------------------------------------------------------
module id_allocator_free_list_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  idal_pkg::req_type    req_data,
   output logic                 rsp_valid,
   output idal_pkg::rsp_type    rsp_data
);

   localparam int IdW  = idal_pkg::IdWidth;
   localparam int IdxW = idal_pkg::IdxWidth;
   localparam logic [IdW-1:0] MaxId = IdW'(idal_pkg::MaxIds);

   idal_pkg::state_type         state_ff, state_in;
   idal_pkg::req_type           req_ff;
   logic [IdW-1:0]              fresh_ff, fresh_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   idal_pkg::rsp_type           rsp_data_ff, rsp_data_in;

   logic                        accept;
   logic                        exec_en;
   idal_pkg::queue_ctrl_type    q_ctrl;
   idal_pkg::queue_status_type  q_status;
   logic [IdxW-1:0]             q_head_idx;
   idal_pkg::mark_wr_type       mark_wr;
   logic                        mark_rd;
   logic [IdxW-1:0]             mark_rd_addr;
   logic [IdxW-1:0]             rel_idx;

   assign accept = start && !busy;

   // request sequencer: next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         idal_pkg::ST_IDLE: begin
            if (start) state_in = idal_pkg::ST_EXEC;
         end
         idal_pkg::ST_EXEC: state_in = idal_pkg::ST_IDLE;
         default:           state_in = idal_pkg::ST_IDLE;
      endcase
   end

   // request sequencer: outputs
   always_comb begin
      busy    = 1'b0;
      exec_en = 1'b0;
      unique case (state_ff)
         idal_pkg::ST_IDLE: begin
            busy    = 1'b0;
            exec_en = 1'b0;
         end
         idal_pkg::ST_EXEC: begin
            busy    = 1'b1;
            exec_en = 1'b1;
         end
         default: begin
            busy    = 1'b0;
            exec_en = 1'b0;
         end
      endcase
   end

   // bitmap read launched at the accept edge from the incoming transaction
   assign mark_rd_addr = IdxW'(req_data.release_id - IdW'(1));
   assign rel_idx      = IdxW'(req_ff.release_id - IdW'(1));

   // decide, update the memories and build the response
   always_comb begin
      fresh_in        = fresh_ff;
      q_ctrl          = '0;
      mark_wr         = '0;
      rsp_valid_in    = exec_en;
      rsp_data_in     = '{granted_id: '0, status: idal_pkg::STATUS_OK};
      if (exec_en) begin
         unique case (req_ff.mode)
            idal_pkg::MODE_ALLOC: begin
               priority if (!q_status.empty) begin
                  // reuse the oldest released identifier
                  q_ctrl.pop             = 1'b1;
                  mark_wr                = '{en: 1'b1, addr: q_head_idx, value: 1'b0};
                  rsp_data_in.granted_id = IdW'(q_head_idx) + IdW'(1);
               end else if (fresh_ff <= MaxId) begin
                  // fresh identifier, its mark entry is cleared on first issue
                  fresh_in               = fresh_ff + IdW'(1);
                  mark_wr                = '{en: 1'b1,
                                             addr: IdxW'(fresh_ff - IdW'(1)),
                                             value: 1'b0};
                  rsp_data_in.granted_id = fresh_ff;
               end else begin
                  rsp_data_in.status     = idal_pkg::STATUS_EXHAUSTED;
               end
            end
            idal_pkg::MODE_RELEASE: begin
               priority if (req_ff.release_id == '0 ||
                            req_ff.release_id >= fresh_ff) begin
                  rsp_data_in.status = idal_pkg::STATUS_UNISSUED;
               end else if (mark_rd) begin
                  rsp_data_in.status = idal_pkg::STATUS_DUPLICATE;
               end else if (!q_status.full) begin
                  q_ctrl.push     = 1'b1;
                  q_ctrl.push_idx = rel_idx;
                  mark_wr         = '{en: 1'b1, addr: rel_idx, value: 1'b1};
               end else begin
                  rsp_data_in.status = idal_pkg::STATUS_OK;
               end
            end
            default: rsp_data_in.status = idal_pkg::STATUS_OK;
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= idal_pkg::ST_IDLE;
         fresh_ff     <= IdW'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      if (exec_en) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   idal_free_queue u_free_queue (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (q_ctrl),
      .status   (q_status),
      .head_idx (q_head_idx)
   );

   idal_mark_map u_mark_map (
      .clock   (clock),
      .rd_addr (mark_rd_addr),
      .wr      (mark_wr),
      .rd_data (mark_rd)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/idal_free_queue.sv =====
// ----------------------------------------------------------------------------
// idal_free_queue
// FIFO of released identifier indexes held in a synchronous memory, with
// head and tail slots and a fill count. The head entry is read every cycle.
// ----------------------------------------------------------------------------
module idal_free_queue (
   input  logic                             clock,
   input  logic                             reset,
   input  idal_pkg::queue_ctrl_type         ctrl,
   output idal_pkg::queue_status_type       status,
   output logic [idal_pkg::IdxWidth-1:0]    head_idx
);

   localparam int IdxW = idal_pkg::IdxWidth;
   localparam int CntW = idal_pkg::CountWidth;
   localparam logic [IdxW-1:0] LastSlot = IdxW'(idal_pkg::MaxIds - 1);
   localparam logic [CntW-1:0] FullCount = CntW'(idal_pkg::MaxIds);

   logic [IdxW-1:0] mem [idal_pkg::MaxIds];
   logic [IdxW-1:0] rd_ff;
   logic [IdxW-1:0] head_ff, head_in;
   logic [IdxW-1:0] tail_ff, tail_in;
   logic [CntW-1:0] count_ff, count_in;

   // storage: write at tail, registered read at head
   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         mem[tail_ff] <= ctrl.push_idx;
      end
      rd_ff <= mem[head_ff];
   end

   // slot and count update
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (ctrl.pop) begin
         head_in = (head_ff == LastSlot) ? '0 : head_ff + IdxW'(1);
      end
      if (ctrl.push) begin
         tail_in = (tail_ff == LastSlot) ? '0 : tail_ff + IdxW'(1);
      end
      if (ctrl.push && !ctrl.pop) begin
         count_in = count_ff + CntW'(1);
      end else if (ctrl.pop && !ctrl.push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == FullCount);
   assign head_idx     = rd_ff;

endmodule

// ===== rtl/idal_mark_map.sv =====
// ----------------------------------------------------------------------------
// idal_mark_map
// One mark bit per identifier, set while the identifier sits in the free
// queue. Synchronous memory with one write port and a registered read.
// ----------------------------------------------------------------------------
module idal_mark_map (
   input  logic                             clock,
   input  logic [idal_pkg::IdxWidth-1:0]    rd_addr,
   input  idal_pkg::mark_wr_type            wr,
   output logic                             rd_data
);

   logic mem [idal_pkg::MaxIds];
   logic rd_ff;

   // bitmap storage
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.value;
      end
      rd_ff <= mem[rd_addr];
   end

   assign rd_data = rd_ff;

endmodule
